[rtl/core/bsd_pkg.sv]
`timescale 1ns / 1ps

package bsd_pkg;

    // parse modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_OCT  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;

    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    // output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic [1:0] left;
    } t_parse_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit digit_of(input logic [7:0] b, input logic [1:0] mode);
        t_digit r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (mode == MODE_OCT) begin
            if (b >= 8'h30 && b <= 8'h37) begin
                r.ok  = 1'b1;
                r.val = b[3:0];
            end
        end else if (b >= 8'h30 && b <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r.ok  = 1'b1;
            r.val = b[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

[rtl/core/bsd_decode.sv]
`timescale 1ns / 1ps

module bsd_decode (
    input  logic                  i_enable,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  bsd_pkg::t_parse_state i_state,
    output bsd_pkg::t_parse_state o_state,
    output bsd_pkg::t_word        o_word0,
    output bsd_pkg::t_word        o_word1
);

    bsd_pkg::t_digit w_dig;
    logic [7:0]      w_acc;
    logic [1:0]      w_left;

    always_comb begin
        w_dig  = bsd_pkg::digit_of(i_byte, i_state.mode);
        w_acc  = (i_state.mode == bsd_pkg::MODE_OCT) ? {i_state.value[4:0], w_dig.val[2:0]}
                                                      : {i_state.value[3:0], w_dig.val};
        w_left = i_state.left - 2'd1;
    end

    always_comb begin
        o_state = i_state;
        o_word0 = '{valid: 1'b0, data: i_byte, last: i_last};
        o_word1 = '{valid: 1'b0, data: i_byte, last: i_last};

        if (!i_enable) begin
            o_state       = '0;
            o_word0.valid = 1'b1;
        end else begin
            case (i_state.mode)
                bsd_pkg::MODE_TEXT: begin
                    if (i_byte == bsd_pkg::CH_BSLASH && !i_last) begin
                        o_state.mode = bsd_pkg::MODE_ESC;
                    end else begin
                        o_word0.valid = 1'b1;
                    end
                end
                bsd_pkg::MODE_ESC: begin
                    o_state.mode  = bsd_pkg::MODE_TEXT;
                    o_word0.valid = 1'b1;
                    case (i_byte)
                        bsd_pkg::CH_A:      o_word0.data = bsd_pkg::CH_BEL;
                        bsd_pkg::CH_B:      o_word0.data = bsd_pkg::CH_BS;
                        bsd_pkg::CH_F:      o_word0.data = bsd_pkg::CH_FF;
                        bsd_pkg::CH_N:      o_word0.data = bsd_pkg::CH_LF;
                        bsd_pkg::CH_R:      o_word0.data = bsd_pkg::CH_CR;
                        bsd_pkg::CH_V:      o_word0.data = bsd_pkg::CH_VT;
                        bsd_pkg::CH_BSLASH: o_word0.data = bsd_pkg::CH_BSLASH;
                        bsd_pkg::CH_ZERO, bsd_pkg::CH_X: begin
                            o_state.value = 8'd0;
                            o_word0.data  = 8'd0;
                            if (!i_last) begin
                                o_word0.valid = 1'b0;
                                o_state.mode  = (i_byte == bsd_pkg::CH_ZERO) ?
                                                bsd_pkg::MODE_OCT : bsd_pkg::MODE_HEX;
                                o_state.left  = (i_byte == bsd_pkg::CH_ZERO) ?
                                                bsd_pkg::OCT_DIGITS : bsd_pkg::HEX_DIGITS;
                            end
                        end
                        default: begin
                            // unknown escape keeps the backslash
                            o_word0.data  = bsd_pkg::CH_BSLASH;
                            o_word0.last  = 1'b0;
                            o_word1.valid = 1'b1;
                        end
                    endcase
                end
                default: begin
                    if (w_dig.ok) begin
                        o_state.value = w_acc;
                        o_state.left  = w_left;
                        if (w_left == 2'd0 || i_last) begin
                            o_word0.valid = 1'b1;
                            o_word0.data  = w_acc;
                            o_state       = '0;
                        end
                    end else begin
                        // flush the value, then treat the byte as plain text
                        o_word0.valid = 1'b1;
                        o_word0.data  = i_state.value;
                        o_word0.last  = 1'b0;
                        o_state       = '0;
                        if (i_byte == bsd_pkg::CH_BSLASH && !i_last) begin
                            o_state.mode = bsd_pkg::MODE_ESC;
                        end else begin
                            o_word1.valid = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

[rtl/core/bsd_outq.sv]
`timescale 1ns / 1ps

module bsd_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsd_pkg::t_word i_word0,
    input  bsd_pkg::t_word i_word1,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic           o_last
);

    logic [8:0] r_mem [bsd_pkg::QUEUE_DEPTH];
    logic [bsd_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [bsd_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [bsd_pkg::QCNT_W-1:0] r_count, n_count;
    logic [bsd_pkg::QCNT_W-1:0] w_push_n;
    logic                       w_pop;
    logic                       w_wr0, w_wr1;
    logic [bsd_pkg::QPTR_W-1:0] w_addr1;

    always_comb begin
        w_wr0    = i_push && i_word0.valid;
        w_wr1    = i_push && i_word1.valid;
        w_push_n = bsd_pkg::QCNT_W'(w_wr0) + bsd_pkg::QCNT_W'(w_wr1);
        w_pop    = o_valid && i_ready;
        w_addr1  = r_wr + bsd_pkg::QPTR_W'(w_wr0);
        n_wr     = r_wr + w_push_n[bsd_pkg::QPTR_W-1:0];
        n_rd     = r_rd + bsd_pkg::QPTR_W'(w_pop);
        n_count  = r_count + w_push_n - bsd_pkg::QCNT_W'(w_pop);
    end

    // room for two words regardless of the output side
    assign o_room  = (r_count <= bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd][8:1];
    assign o_last  = r_mem[r_rd][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr0) begin
            r_mem[r_wr] <= {i_word0.data, i_word0.last};
        end
        if (w_wr1) begin
            r_mem[w_addr1] <= {i_word1.data, i_word1.last};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_n != '0 |-> (r_count + w_push_n) <= bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_push_n == '0) |=> r_count == $past(r_count) - 1'b1)
        else $error("output queue count did not drop on pop");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr1 |-> w_wr0)
        else $error("second word pushed without first");

endmodule

[rtl/core/backslash_escape_decoder.sv]
`timescale 1ns / 1ps
// each accepted word writes its results into the output queue, which presents them in order
// throughput: one word per cycle; a word that yields two results fills two queue slots
// and the input stalls while fewer than two of the four output queue slots are free
// reset: synchronous active-low; clears the parse state, the queue and escape_enable

module backslash_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic                  r_enable;
    bsd_pkg::t_parse_state r_state, n_state;
    bsd_pkg::t_word        w_word0, w_word1;
    logic                  w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    bsd_decode u_decode (
        .i_enable (r_enable),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_word0  (w_word0),
        .o_word1  (w_word1)
    );

    bsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_word0 (w_word0),
        .i_word1 (w_word1),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_byte),
        .o_last  (o_out_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_state  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_state <= n_state;
            end
        end
    end

    a_last_ends_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> r_state.mode == bsd_pkg::MODE_TEXT)
        else $error("escape still open after final word");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |-> w_word0.valid)
        else $error("final word produced no result");

    a_disabled_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_enable) |=> r_state == '0)
        else $error("parse state kept while escapes disabled");

endmodule
